// ----- rtl/hlcd_pkg.sv -----
// Shared constants and types for the header/length/checksum deframer.
// No dependencies.
`timescale 1ns / 1ps

package hlcd_pkg;

    // Frame store geometry: header, function, two length bytes, payload, checksum
    localparam int unsigned MAX_PAYLOAD = 59;
    localparam int unsigned STORE_DEPTH = MAX_PAYLOAD + 5;
    localparam int unsigned ADDR_W      = $clog2(STORE_DEPTH);
    localparam int unsigned LEN_W       = 16;

    typedef logic [2:0] phase_t;
    typedef logic [1:0] status_t;

    localparam logic [7:0] HDR_RESET = 8'hA5;

    // Parser phases
    localparam phase_t PH_HUNT = 3'd0;
    localparam phase_t PH_FUNC = 3'd1;
    localparam phase_t PH_LEN  = 3'd2;
    localparam phase_t PH_PAY  = 3'd3;
    localparam phase_t PH_SUM  = 3'd4;
    localparam phase_t PH_EMIT = 3'd5;

    // Result status codes
    localparam status_t ST_OK      = 2'd0;
    localparam status_t ST_SUM_ERR = 2'd1;
    localparam status_t ST_LEN_ERR = 2'd2;

    // Fixed store offsets
    localparam logic [ADDR_W-1:0] ADDR_HDR     = ADDR_W'(0);
    localparam logic [ADDR_W-1:0] ADDR_FUNC    = ADDR_W'(1);
    localparam logic [ADDR_W-1:0] ADDR_LEN     = ADDR_W'(2);
    localparam logic [ADDR_W-1:0] ADDR_PAY     = ADDR_W'(4);

endpackage

// ----- rtl/header_length_checksum_deframer.sv -----
// Top level of the header/length/sum-8 checksum deframer with its frame store.
// Depends on hlcd_pkg.
`timescale 1ns / 1ps

// Byte-stream deframer. Received bytes enter on the s_ side, one item per
// byte. The block hunts for the header byte (cfg register, 0xA5 after reset),
// then takes a function code, a big-endian 16-bit length, that many payload
// bytes and a checksum equal to the 8-bit sum of function, length and
// payload. Every frame byte is written into a 64-entry frame store. A good
// frame is replayed from the store on the m_ side, header through checksum,
// m_tuser = 0, m_tlast on the checksum byte. A bad checksum gives one item
// with m_tuser = 1 and the computed sum; a length above 59 gives one item
// with m_tuser = 2 and data zero, flagged when the second length byte
// arrives. Both error items carry m_tlast. Rate: while parsing, one input
// byte is taken per cycle whenever the output register is empty or being
// drained. After a good checksum the block holds s_tready low while it
// replays the N+5 bytes. Store reads are registered, one in flight at a
// time. Non-header bytes while hunting give nothing.
module header_length_checksum_deframer (
    input  logic       aclk,
    input  logic       aresetn,
    // configuration: header byte value
    input  logic       cfg_wr_en,
    input  logic [7:0] cfg_wr_data,
    // received bytes
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,    // [7:0] rx_byte
    // results
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,    // [7:0] frame_byte
    output logic [1:0] m_tuser,    // [1:0] status
    output logic       m_tlast
);

    localparam int unsigned AW = hlcd_pkg::ADDR_W;
    localparam int unsigned LW = hlcd_pkg::LEN_W;

    // ---------------------------------------------------------------
    // Frame store: one write port, one registered read port
    // ---------------------------------------------------------------
    logic [7:0]    store_mem [hlcd_pkg::STORE_DEPTH];
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    logic          rd_en;
    logic [7:0]    rd_data_reg;

    // ---------------------------------------------------------------
    // Control state
    // ---------------------------------------------------------------
    logic [7:0]        hdr_reg;
    hlcd_pkg::phase_t  phase_reg, phase_next;
    logic              len_idx_reg, len_idx_next;
    logic [AW-1:0]     pay_idx_reg, pay_idx_next;
    logic [LW-1:0]     len_reg, len_next;
    logic [7:0]        sum_reg, sum_next;
    logic [AW-1:0]     emit_addr_reg, emit_addr_next;
    logic              rd_pend_reg, rd_pend_next;
    logic              rd_last_reg, rd_last_next;
    logic              rd_done_reg, rd_done_next;

    // output register
    logic              m_valid_reg, m_valid_next;
    logic [7:0]        m_data_reg, m_data_next;
    hlcd_pkg::status_t m_user_reg, m_user_next;
    logic              m_last_reg, m_last_next;

    logic          out_free;
    logic          s_accept;
    logic [7:0]    sum_add;
    logic [LW-1:0] len_full;
    logic [LW-1:0] pay_cnt;
    logic [AW-1:0] emit_last_addr;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            store_mem[wr_addr] <= s_tdata;
        end
        if (rd_en) begin
            rd_data_reg <= store_mem[emit_addr_reg];
        end
    end

    assign out_free       = !m_valid_reg || m_tready;
    assign s_tready       = (phase_reg != hlcd_pkg::PH_EMIT) && out_free;
    assign s_accept       = s_tvalid && s_tready;
    assign sum_add        = sum_reg + s_tdata;
    assign len_full       = {len_reg[LW-1:8], s_tdata};
    assign pay_cnt        = LW'(pay_idx_reg) + LW'(1);
    // checksum sits at length + 4; length is at most MAX_PAYLOAD here
    assign emit_last_addr = len_reg[AW-1:0] + hlcd_pkg::ADDR_PAY;

    // replay reads: one in flight, only when the output slot will be free
    assign rd_en = (phase_reg == hlcd_pkg::PH_EMIT) && !rd_pend_reg && !rd_done_reg
                   && out_free;

    always_comb begin
        phase_next     = phase_reg;
        len_idx_next   = len_idx_reg;
        pay_idx_next   = pay_idx_reg;
        len_next       = len_reg;
        sum_next       = sum_reg;
        emit_addr_next = emit_addr_reg;
        rd_pend_next   = rd_en;
        rd_last_next   = rd_last_reg;
        rd_done_next   = rd_done_reg;
        wr_en          = 1'b0;
        wr_addr        = hlcd_pkg::ADDR_HDR;
        m_valid_next   = m_valid_reg && !m_tready;
        m_data_next    = m_data_reg;
        m_user_next    = m_user_reg;
        m_last_next    = m_last_reg;

        if (s_accept) begin
            unique case (phase_reg)
                hlcd_pkg::PH_FUNC: begin
                    wr_en        = 1'b1;
                    wr_addr      = hlcd_pkg::ADDR_FUNC;
                    sum_next     = sum_add;
                    len_idx_next = 1'b0;
                    phase_next   = hlcd_pkg::PH_LEN;
                end
                hlcd_pkg::PH_LEN: begin
                    wr_en    = 1'b1;
                    wr_addr  = hlcd_pkg::ADDR_LEN | AW'(len_idx_reg);
                    sum_next = sum_add;
                    if (!len_idx_reg) begin
                        len_next     = {s_tdata, len_reg[7:0]};
                        len_idx_next = 1'b1;
                    end else begin
                        len_next     = len_full;
                        len_idx_next = 1'b0;
                        pay_idx_next = '0;
                        if (len_full == '0) begin
                            phase_next = hlcd_pkg::PH_SUM;
                        end else if (len_full > LW'(hlcd_pkg::MAX_PAYLOAD)) begin
                            // oversize: flag and drop the frame
                            m_valid_next = 1'b1;
                            m_data_next  = 8'd0;
                            m_user_next  = hlcd_pkg::ST_LEN_ERR;
                            m_last_next  = 1'b1;
                            sum_next     = 8'd0;
                            phase_next   = hlcd_pkg::PH_HUNT;
                        end else begin
                            phase_next = hlcd_pkg::PH_PAY;
                        end
                    end
                end
                hlcd_pkg::PH_PAY: begin
                    wr_en    = 1'b1;
                    wr_addr  = hlcd_pkg::ADDR_PAY + pay_idx_reg;
                    sum_next = sum_add;
                    if (pay_cnt >= len_reg) begin
                        pay_idx_next = '0;
                        phase_next   = hlcd_pkg::PH_SUM;
                    end else begin
                        pay_idx_next = pay_idx_reg + AW'(1);
                    end
                end
                hlcd_pkg::PH_SUM: begin
                    if (sum_reg == s_tdata) begin
                        wr_en          = 1'b1;
                        wr_addr        = emit_last_addr;
                        emit_addr_next = '0;
                        rd_done_next   = 1'b0;
                        rd_last_next   = 1'b0;
                        phase_next     = hlcd_pkg::PH_EMIT;
                    end else begin
                        m_valid_next = 1'b1;
                        m_data_next  = sum_reg;
                        m_user_next  = hlcd_pkg::ST_SUM_ERR;
                        m_last_next  = 1'b1;
                        phase_next   = hlcd_pkg::PH_HUNT;
                    end
                    sum_next     = 8'd0;
                    pay_idx_next = '0;
                    len_idx_next = 1'b0;
                end
                default: begin
                    // hunting; unused codes behave the same
                    phase_next = hlcd_pkg::PH_HUNT;
                    if (s_tdata == hdr_reg) begin
                        wr_en      = 1'b1;
                        wr_addr    = hlcd_pkg::ADDR_HDR;
                        sum_next   = 8'd0;
                        phase_next = hlcd_pkg::PH_FUNC;
                    end
                end
            endcase
        end

        // replay sequencing
        if (rd_en) begin
            rd_last_next   = (emit_addr_reg == emit_last_addr);
            rd_done_next   = (emit_addr_reg == emit_last_addr);
            emit_addr_next = emit_addr_reg + AW'(1);
        end
        if (rd_pend_reg) begin
            m_valid_next = 1'b1;
            m_data_next  = rd_data_reg;
            m_user_next  = hlcd_pkg::ST_OK;
            m_last_next  = rd_last_reg;
            if (rd_last_reg) begin
                phase_next   = hlcd_pkg::PH_HUNT;
                rd_last_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_reg       <= hlcd_pkg::HDR_RESET;
            phase_reg     <= hlcd_pkg::PH_HUNT;
            len_idx_reg   <= 1'b0;
            pay_idx_reg   <= '0;
            len_reg       <= '0;
            sum_reg       <= 8'd0;
            emit_addr_reg <= '0;
            rd_pend_reg   <= 1'b0;
            rd_last_reg   <= 1'b0;
            rd_done_reg   <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_wr_en) begin
                hdr_reg <= cfg_wr_data;
            end
            phase_reg     <= phase_next;
            len_idx_reg   <= len_idx_next;
            pay_idx_reg   <= pay_idx_next;
            len_reg       <= len_next;
            sum_reg       <= sum_next;
            emit_addr_reg <= emit_addr_next;
            rd_pend_reg   <= rd_pend_next;
            rd_last_reg   <= rd_last_next;
            rd_done_reg   <= rd_done_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // payload of the output register
    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
        m_user_reg <= m_user_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tuser  = m_user_reg;
    assign m_tlast  = m_last_reg;

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    // a store read in flight always finds the output slot empty
    a_pend_slot_free: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> !m_valid_reg)
        else $error("replay read landed on an occupied output register");

    // replay reads only happen during emission
    a_pend_in_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_pend_reg |-> (phase_reg == hlcd_pkg::PH_EMIT))
        else $error("store read in flight outside emission");

    // input is held off for the whole replay
    a_no_input_emit: assert property (@(posedge aclk) disable iff (!aresetn)
        (phase_reg == hlcd_pkg::PH_EMIT) |-> !s_tready)
        else $error("input accepted during frame replay");

    // every error item closes its run
    a_err_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && (m_tuser != hlcd_pkg::ST_OK)) |-> m_tlast)
        else $error("error item without last");

endmodule
